### rtl/swdb_pkg.sv
// Shared types and constants for the switch debouncer with chatter lockout.
// Holds the operation, event and register index codes and the interface structs.
// Depends on nothing.
`timescale 1ns / 1ps

package swdb_pkg;

   localparam int unsigned CNT_W = 8;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W = 8;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE_THRESHOLD = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_EDGES_PER_SECOND = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_WINDOWS = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_HAS_PARENT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PORT_ID = 3'd4;

   typedef enum logic [1:0] {
      EDGE_NONE = 2'd0,
      EDGE_RISE = 2'd1,
      EDGE_FALL = 2'd2
   } edge_event_type;

   typedef struct packed {
      logic [CNT_W-1:0] debounce_threshold;
      logic [CNT_W-1:0] max_edges_per_second;
      logic [CNT_W-1:0] max_windows;
      logic             has_parent;
      logic [CNT_W-1:0] port_id;
   } cfg_type;

   typedef struct packed {
      edge_event_type   edge_event;
      logic [CNT_W-1:0] event_port;
      logic             level_changed;
      logic             latched_level;
      logic             input_enabled;
      logic             monitor_active;
   } result_type;

   typedef struct packed {
      logic enabled;
      logic monitor;
   } status_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      sat_inc = (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
   endfunction

endpackage

### rtl/swdb_csr.sv
// Configuration register bank of the switch debouncer.
// Uses swdb_pkg for the register index codes and the configuration struct.
`timescale 1ns / 1ps

module swdb_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [swdb_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [swdb_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output swdb_pkg::cfg_type                  cfg
);
   import swdb_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_DEBOUNCE_THRESHOLD:   cfg_in.debounce_threshold = csr_wdata;
            CSR_MAX_EDGES_PER_SECOND: cfg_in.max_edges_per_second = csr_wdata;
            CSR_MAX_WINDOWS:          cfg_in.max_windows = csr_wdata;
            CSR_HAS_PARENT:           cfg_in.has_parent = csr_wdata[0];
            CSR_PORT_ID:              cfg_in.port_id = csr_wdata;
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_threshold <= 8'd3;
         cfg_ff.max_edges_per_second <= 8'd10;
         cfg_ff.max_windows <= 8'd10;
         cfg_ff.has_parent <= 1'b1;
         cfg_ff.port_id <= 8'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### rtl/swdb_core.sv
// Debounce and chatter monitor state with its single-pass update logic.
// Uses swdb_pkg for the configuration, result and status structs.
`timescale 1ns / 1ps

module swdb_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic                 op,
   input  logic                 level,
   input  swdb_pkg::cfg_type    cfg,
   output swdb_pkg::result_type res,
   output swdb_pkg::status_type status
);
   import swdb_pkg::*;

   logic             held_level_ff, held_level_in;
   logic [CNT_W-1:0] stable_count_ff, stable_count_in;
   logic             edge_pending_ff, edge_pending_in;
   logic [CNT_W-1:0] edges_in_window_ff, edges_in_window_in;
   logic [CNT_W-1:0] windows_seen_ff, windows_seen_in;
   logic             enabled_ff, enabled_in;
   logic             monitor_ff, monitor_in;

   logic             changed;
   logic [CNT_W-1:0] count_next;
   edge_event_type   event_code;

   always_comb begin
      held_level_in = held_level_ff;
      stable_count_in = stable_count_ff;
      edge_pending_in = edge_pending_ff;
      edges_in_window_in = edges_in_window_ff;
      windows_seen_in = windows_seen_ff;
      enabled_in = enabled_ff;
      monitor_in = monitor_ff;
      changed = 1'b0;
      event_code = EDGE_NONE;
      count_next = sat_inc(stable_count_ff);

      if (op == OP_SAMPLE) begin
         changed = (level != held_level_ff);
         held_level_in = level;
         count_next = changed ? {{(CNT_W-1){1'b0}}, 1'b1} : sat_inc(stable_count_ff);
         if (changed || edge_pending_ff) begin
            edge_pending_in = 1'b1;
            stable_count_in = count_next;
            if (enabled_ff && (count_next > cfg.debounce_threshold)) begin
               stable_count_in = '0;
               edge_pending_in = 1'b0;
               if (level) begin
                  event_code = EDGE_RISE;
                  if (cfg.has_parent && monitor_ff) begin
                     edges_in_window_in = sat_inc(edges_in_window_ff);
                  end
               end else begin
                  event_code = EDGE_FALL;
               end
            end
         end
      end else if (monitor_ff) begin
         if (edges_in_window_ff >= cfg.max_edges_per_second) begin
            enabled_in = 1'b0;
            monitor_in = 1'b0;
         end else begin
            edges_in_window_in = '0;
            windows_seen_in = sat_inc(windows_seen_ff);
         end
         if (windows_seen_in >= cfg.max_windows) begin
            monitor_in = 1'b0;
         end
      end
   end

   always_comb begin
      res.edge_event = event_code;
      res.event_port = (event_code != EDGE_NONE) ? cfg.port_id : '0;
      res.level_changed = changed;
      res.latched_level = held_level_in;
      res.input_enabled = enabled_in;
      res.monitor_active = monitor_in;
      status.enabled = enabled_ff;
      status.monitor = monitor_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_level_ff <= 1'b0;
         stable_count_ff <= '0;
         edge_pending_ff <= 1'b0;
         edges_in_window_ff <= '0;
         windows_seen_ff <= '0;
         enabled_ff <= 1'b1;
         monitor_ff <= 1'b1;
      end else if (step) begin
         held_level_ff <= held_level_in;
         stable_count_ff <= stable_count_in;
         edge_pending_ff <= edge_pending_in;
         edges_in_window_ff <= edges_in_window_in;
         windows_seen_ff <= windows_seen_in;
         enabled_ff <= enabled_in;
         monitor_ff <= monitor_in;
      end
   end

endmodule

### rtl/switch_debounce_with_chatter_lockout_unit.sv
// Switch debouncer with chatter lockout: input register, update logic, result register.
// A req_ transfer loads the input register; the result register then offers the rsp_ result.
// Throughput is one item per cycle while rsp_ready does not stall the result register.
// Synchronous active-high reset clears both valid flags and the state and sets CSR defaults.
// Depends on swdb_pkg, swdb_csr and swdb_core.
`timescale 1ns / 1ps

module switch_debounce_with_chatter_lockout_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_operation,
   input  logic                             req_sample_level,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [1:0]                       rsp_edge_event,
   output logic [7:0]                       rsp_event_port,
   output logic                             rsp_level_changed,
   output logic                             rsp_latched_level,
   output logic                             rsp_input_enabled,
   output logic                             rsp_monitor_active,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [swdb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [swdb_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import swdb_pkg::*;

   cfg_type    cfg;
   result_type res;
   status_type status;

   logic       in_valid_ff, in_valid_in;
   logic       in_op_ff;
   logic       in_level_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;
   logic       advance;
   logic       req_take;

   swdb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   swdb_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .op     (in_op_ff),
      .level  (in_level_ff),
      .cfg    (cfg),
      .res    (res),
      .status (status)
   );

   assign advance = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take = req_valid && req_ready;
   assign in_valid_in = req_take || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_op_ff <= req_operation;
         in_level_ff <= req_sample_level;
      end
      if (advance) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_edge_event = rsp_ff.edge_event;
   assign rsp_event_port = rsp_ff.event_port;
   assign rsp_level_changed = rsp_ff.level_changed;
   assign rsp_latched_level = rsp_ff.latched_level;
   assign rsp_input_enabled = rsp_ff.input_enabled;
   assign rsp_monitor_active = rsp_ff.monitor_active;

   a_no_event_no_port: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.edge_event == EDGE_NONE |-> rsp_ff.event_port == '0)
      else $error("Port number reported without an edge event.");

   a_rise_high_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.edge_event == EDGE_RISE |-> rsp_ff.latched_level)
      else $error("Rising edge reported with a low latched level.");

   a_lockout_stops_monitor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.input_enabled |-> !rsp_ff.monitor_active)
      else $error("Monitor still running after lockout.");

   a_lockout_sticky: assert property (@(posedge clock) disable iff (reset)
      !status.enabled |=> !status.enabled)
      else $error("Input re-enabled after lockout.");

endmodule

### tb/debounce_tracker_pkg.sv
// Scoreboard class for the switch debouncer testbench: mirrors the debouncer state and
// configuration, and checks each response transfer against the oldest outstanding result.
// Depends on swdb_pkg.
`timescale 1ns / 1ps

package debounce_tracker_pkg;
   import swdb_pkg::*;

   class debounce_tracker;
      logic [7:0] threshold;
      logic [7:0] edge_limit;
      logic [7:0] window_limit;
      logic       parent;
      logic [7:0] port;
      logic       held;
      logic       armed;
      logic       enabled;
      logic       monitoring;
      logic [7:0] stable;
      logic [7:0] edge_count;
      logic [7:0] windows;
      result_type outcomes_due[$];
      int         mismatches;

      function new();
         threshold = 8'd3;
         edge_limit = 8'd10;
         window_limit = 8'd10;
         parent = 1'b1;
         port = 8'd0;
         held = 1'b0;
         armed = 1'b0;
         enabled = 1'b1;
         monitoring = 1'b1;
         stable = 8'd0;
         edge_count = 8'd0;
         windows = 8'd0;
         mismatches = 0;
      endfunction

      function void report(string what);
         if (mismatches < 100)
            $display("%0t ns: %s", $time, what);
         mismatches++;
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] index,
                                   logic [CSR_DATA_W-1:0] value);
         case (index)
            CSR_DEBOUNCE_THRESHOLD: threshold = value;
            CSR_MAX_EDGES_PER_SECOND: edge_limit = value;
            CSR_MAX_WINDOWS: window_limit = value;
            CSR_HAS_PARENT: parent = value[0];
            CSR_PORT_ID: port = value;
            default: ;
         endcase
      endfunction

      function void note_request(logic op, logic lvl);
         result_type r;
         r = '0;
         if (op == OP_SAMPLE) begin
            if (lvl != held) begin
               r.level_changed = 1'b1;
               held = lvl;
               stable = 8'd0;
               armed = 1'b1;
            end
            if (armed) begin
               if (stable != 8'hFF)
                  stable++;
               if (enabled && stable > threshold) begin
                  stable = 8'd0;
                  armed = 1'b0;
                  r.event_port = port;
                  if (held) begin
                     r.edge_event = EDGE_RISE;
                     if (parent && monitoring && edge_count != 8'hFF)
                        edge_count++;
                  end else begin
                     r.edge_event = EDGE_FALL;
                  end
               end
            end
         end else if (monitoring) begin
            if (edge_count >= edge_limit) begin
               enabled = 1'b0;
               monitoring = 1'b0;
            end else begin
               edge_count = 8'd0;
               if (windows != 8'hFF)
                  windows++;
            end
            if (windows >= window_limit)
               monitoring = 1'b0;
         end
         r.latched_level = held;
         r.input_enabled = enabled;
         r.monitor_active = monitoring;
         outcomes_due.push_back(r);
      endfunction

      function void compare_field(string name, logic [7:0] got, logic [7:0] want);
         if (got !== want)
            report($sformatf("%s mismatch: got %0d, expected %0d", name, got, want));
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (outcomes_due.size() == 0) begin
            report("response transfer with no result outstanding");
            return;
         end
         want = outcomes_due.pop_front();
         compare_field("edge_event", 8'(got.edge_event), 8'(want.edge_event));
         compare_field("event_port", got.event_port, want.event_port);
         compare_field("level_changed", 8'(got.level_changed), 8'(want.level_changed));
         compare_field("latched_level", 8'(got.latched_level), 8'(want.latched_level));
         compare_field("input_enabled", 8'(got.input_enabled), 8'(want.input_enabled));
         compare_field("monitor_active", 8'(got.monitor_active), 8'(want.monitor_active));
      endfunction

      function int outstanding();
         return outcomes_due.size();
      endfunction
   endclass

endpackage

### tb/switch_debounce_with_chatter_lockout_unit_test.sv
// Top-level testbench for switch_debounce_with_chatter_lockout_unit: directed and random
// samples and ticks under varied back-pressure, checked by the debounce_tracker class.
// Depends on swdb_pkg, debounce_tracker_pkg and the unit under test.
`timescale 1ns / 1ps

module switch_debounce_with_chatter_lockout_unit_test;
   import swdb_pkg::*;
   import debounce_tracker_pkg::*;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;
   typedef enum int {
      END_ZERO_EDGE_LIMIT,
      END_ZERO_WINDOW_LIMIT,
      END_EDGE_FLOOD,
      END_WINDOW_RUN_OUT
   } finale_type;

   localparam int HOLD_CYCLES = 150;
   localparam int STALL_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 6;

   localparam logic [1:0] DIRECTED_ITEMS [23] = '{
      {OP_SAMPLE, 1'b0}, {OP_SAMPLE, 1'b1}, {OP_SAMPLE, 1'b1}, {OP_SAMPLE, 1'b1},
      {OP_SAMPLE, 1'b1}, {OP_SAMPLE, 1'b1}, {OP_SAMPLE, 1'b0}, {OP_SAMPLE, 1'b1},
      {OP_SAMPLE, 1'b1}, {OP_SAMPLE, 1'b1}, {OP_SAMPLE, 1'b1}, {OP_TICK, 1'b0},
      {OP_SAMPLE, 1'b0}, {OP_SAMPLE, 1'b0}, {OP_TICK, 1'b1}, {OP_SAMPLE, 1'b0},
      {OP_SAMPLE, 1'b0}, {OP_SAMPLE, 1'b1}, {OP_SAMPLE, 1'b1}, {OP_TICK, 1'b0},
      {OP_SAMPLE, 1'b1}, {OP_SAMPLE, 1'b1}, {OP_SAMPLE, 1'b0}
   };

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic                   req_operation = OP_SAMPLE;
   logic                   req_sample_level = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [1:0]             rsp_edge_event;
   logic [7:0]             rsp_event_port;
   logic                   rsp_level_changed;
   logic                   rsp_latched_level;
   logic                   rsp_input_enabled;
   logic                   rsp_monitor_active;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_DEBOUNCE_THRESHOLD;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   debounce_tracker tracker;
   idle_mode_type   idle_mode = IDLE_NONE;
   int              items_sent = 0;
   bit              hold_request = 1'b0;
   int              hold_left = 0;
   int              quiet_cycles = 0;
   logic            run_level = 1'b0;
   int              run_left = 0;

   always #5 clock = ~clock;

   switch_debounce_with_chatter_lockout_unit u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_sample_level   (req_sample_level),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_edge_event     (rsp_edge_event),
      .rsp_event_port     (rsp_event_port),
      .rsp_level_changed  (rsp_level_changed),
      .rsp_latched_level  (rsp_latched_level),
      .rsp_input_enabled  (rsp_input_enabled),
      .rsp_monitor_active (rsp_monitor_active),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   function automatic bit sender_pauses();
      case (idle_mode)
         IDLE_SENDER: return $urandom_range(0, 99) < 54;
         IDLE_BOTH: return $urandom_range(0, 99) < 27;
         default: return 1'b0;
      endcase
   endfunction

   function automatic bit receiver_stalls();
      case (idle_mode)
         IDLE_RECEIVER: return $urandom_range(0, 99) < 54;
         IDLE_BOTH: return $urandom_range(0, 99) < 27;
         default: return 1'b0;
      endcase
   endfunction

   always @(posedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !receiver_stalls();
      end
   end

   // Outputs and inputs only change at the rising edge, so the handshake seen at the
   // falling edge is the one that completes at the next rising edge.
   always @(negedge clock) begin
      result_type seen;
      if (!reset && rsp_valid && rsp_ready) begin
         seen.edge_event = edge_event_type'(rsp_edge_event);
         seen.event_port = rsp_event_port;
         seen.level_changed = rsp_level_changed;
         seen.latched_level = rsp_latched_level;
         seen.input_enabled = rsp_input_enabled;
         seen.monitor_active = rsp_monitor_active;
         tracker.check_result(seen);
      end
   end

   always @(negedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL switch_debounce_with_chatter_lockout_unit");
            $finish;
         end
      end
   end

   task automatic send_item(input logic op, input logic lvl);
      while (sender_pauses()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_sample_level <= lvl;
      @(negedge clock);
      while (!req_ready)
         @(negedge clock);
      tracker.note_request(op, lvl);
      @(posedge clock);
      items_sent++;
      if (items_sent % 64 == 0)
         idle_mode = idle_mode_type'((int'(idle_mode) + 1) % 4);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (tracker.outstanding() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      while (!csr_ready)
         @(negedge clock);
      tracker.write_register(index, value);
      @(posedge clock);
   endtask

   task automatic configure(input logic [7:0] thr, input logic [7:0] edge_lim,
                            input logic [7:0] win_lim, input logic parent,
                            input logic [7:0] port);
      write_reg(CSR_DEBOUNCE_THRESHOLD, thr);
      write_reg(CSR_MAX_EDGES_PER_SECOND, edge_lim);
      write_reg(CSR_MAX_WINDOWS, win_lim);
      write_reg(CSR_HAS_PARENT, {7'd0, parent});
      write_reg(CSR_PORT_ID, port);
      csr_valid <= 1'b0;
   endtask

   // Mostly steady runs of one level so that edges get confirmed, with some glitches.
   task automatic send_random(input int count, input int tick_permille);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 999) < tick_permille) begin
            send_item(OP_TICK, 1'($urandom));
         end else begin
            if (run_left == 0) begin
               run_level = ~run_level;
               run_left = $urandom_range(1, 9);
            end
            run_left--;
            if ($urandom_range(0, 9) == 0)
               send_item(OP_SAMPLE, 1'($urandom));
            else
               send_item(OP_SAMPLE, run_level);
         end
      end
   endtask

   initial begin
      finale_type finale;
      tracker = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ITEMS[k])
         send_item(DIRECTED_ITEMS[k][1], DIRECTED_ITEMS[k][0]);
      settle();

      configure(8'd0, 8'd1, 8'd255, 1'b0, 8'h5A);
      send_random(250, 32);
      settle();

      configure(8'($urandom_range(1, 6)), 8'd255, 8'd255, 1'b1, 8'hFF);
      send_random(100, 40);
      hold_request = 1'b1;
      send_random(150, 40);
      settle();

      // The stable counter saturates while the threshold cannot be passed, then a
      // lower threshold lets the saturated count confirm the edge.
      configure(8'd255, 8'd255, 8'd255, 1'b1, 8'hA5);
      send_item(OP_SAMPLE, 1'b0);
      repeat (301) send_item(OP_SAMPLE, 1'b1);
      settle();
      configure(8'd254, 8'd255, 8'd255, 1'b1, 8'hA5);
      send_item(OP_SAMPLE, 1'b1);
      send_random(20, 0);
      settle();

      finale = finale_type'($urandom_range(0, 3));
      case (finale)
         END_ZERO_EDGE_LIMIT: begin
            configure(8'd2, 8'd0, 8'd255, 1'b1, 8'h3C);
            send_random(30, 0);
            send_item(OP_TICK, 1'b0);
         end
         END_ZERO_WINDOW_LIMIT: begin
            configure(8'd1, 8'd255, 8'd0, 1'b1, 8'hC3);
            send_random(30, 0);
            send_item(OP_TICK, 1'b1);
         end
         END_EDGE_FLOOD: begin
            configure(8'd0, 8'd255, 8'd255, 1'b1, 8'h81);
            send_item(OP_TICK, 1'b0);
            for (int i = 0; i < 520; i++)
               send_item(OP_SAMPLE, 1'(i));
            send_item(OP_TICK, 1'b0);
         end
         default: begin
            configure(8'd1, 8'd255, 8'd255, 1'b1, 8'h7E);
            repeat (260) send_item(OP_TICK, 1'($urandom));
         end
      endcase
      settle();

      send_random(150, 125);
      settle();

      if (tracker.mismatches == 0)
         $display("PASS switch_debounce_with_chatter_lockout_unit");
      else
         $display("FAIL switch_debounce_with_chatter_lockout_unit");
      $finish;
   end

endmodule
